// ===== sv/banked_video_ram_with_block_dma_macros.svh =====
// Assertion macros shared by the video RAM block.
`ifndef BANKED_VIDEO_RAM_WITH_BLOCK_DMA_MACROS_SVH
`define BANKED_VIDEO_RAM_WITH_BLOCK_DMA_MACROS_SVH
`ifndef ASSERT_OFF
// Checked while out of reset.
`define BVR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define BVR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BVR_ASSERT(lbl, prop, msg)
`define BVR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/bvr_pkg.sv =====
// Shared constants and types for the banked video RAM with block copy engine.
package bvr_pkg;

  localparam int BANK_BYTES_DEF = 8192;
  localparam int BLOCK_BYTES    = 16;

  localparam logic [15:0] VRAM_BASE    = 16'h8000;
  localparam logic [15:0] ADDR_BANK    = 16'hFF4F;
  localparam logic [15:0] ADDR_SRC_HI  = 16'hFF51;
  localparam logic [15:0] ADDR_SRC_LO  = 16'hFF52;
  localparam logic [15:0] ADDR_DST_HI  = 16'hFF53;
  localparam logic [15:0] ADDR_DST_LO  = 16'hFF54;
  localparam logic [15:0] ADDR_CTRL    = 16'hFF55;

  localparam logic [7:0] LO_MASK      = 8'hF0;
  localparam logic [7:0] DST_HI_MASK  = 8'h1F;
  localparam logic [7:0] CTRL_HBLANK  = 8'h80;
  localparam logic [7:0] LEN_MASK     = 8'h7F;
  localparam logic [7:0] UNMAPPED     = 8'hFF;
  localparam logic [7:0] REG_RESET    = 8'hFF;

  localparam logic [5:0] TICKS_PER_BLOCK = 6'd32;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_DMA   = 2'd3
  } op_t;

  typedef enum logic {
    KIND_READ  = 1'b0,
    KIND_FETCH = 1'b1
  } kind_t;

  // Result waiting for the VRAM read data.
  typedef struct packed {
    kind_t       kind;
    logic        use_mem;
    logic [7:0]  reg_data;
    logic [15:0] fetch_addr;
    logic        busy;
  } res_t;

endpackage

// ===== sv/banked_video_ram_with_block_dma.sv =====
// Top level: banked video RAM, register file and block copy engine.
//
// Input channel (in_*): one bus read, bus write, tick or copy source byte per
// beat. Output channel (out_*): one beat for each bus read (kind 0) and one
// for each block fetch request (kind 1). Config channel (cfg_*): color mode,
// always ready; write it only while the block is idle.
// Throughput: one input beat per cycle. All state updates happen at the
// accepting edge; VRAM is a single-port RAM with registered read data, so a
// result goes from its input beat through the RAM read stage into the
// output register, and out_valid rises when it arrives there.
// When the receiver stalls, the output register holds and the read stage
// behind it fills; the input channel then drops ready until the output beat
// is taken. At reset the bank and copy registers read 0xFF, the copy engine
// is idle and color mode is off. VRAM contents are undefined until written.
`include "banked_video_ram_with_block_dma_macros.svh"
module banked_video_ram_with_block_dma
  import bvr_pkg::*;
#(
  parameter int BANK_BYTES = BANK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_color_mode,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [1:0]  in_display_mode,
  input  logic [7:0]  in_dma_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_read_data,
  output logic [15:0] out_fetch_address,
  output logic        out_copy_busy
);

  localparam int DEPTH = 2 * BANK_BYTES;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int OFS_W = $clog2(BANK_BYTES);

  // Wrap a 13-bit offset into the bank: compare against multiples one to seven
  // at once and subtract the largest one that fits.
  function automatic logic [OFS_W-1:0] wrap_bank(input logic [12:0] v);
    logic [15:0] t;
    logic [15:0] sub;
    t   = {3'b000, v};
    sub = 16'd0;
    for (int i = 1; i < 8; i++) begin
      if (t >= 16'(i * BANK_BYTES)) sub = 16'(i * BANK_BYTES);
    end
    t = t - sub;
    return t[OFS_W-1:0];
  endfunction

  // Control registers.
  logic        color_mode_r;
  logic [7:0]  bank_r, bank_nxt;
  logic [7:0]  src_hi_r, src_hi_nxt;
  logic [7:0]  src_lo_r, src_lo_nxt;
  logic [7:0]  dst_hi_r, dst_hi_nxt;
  logic [7:0]  dst_lo_r, dst_lo_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        active_r, active_nxt;
  logic        hblank_r, hblank_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [15:0] src_ptr_r, src_ptr_nxt;
  logic [12:0] dst_ptr_r, dst_ptr_nxt;
  logic [11:0] rem_r, rem_nxt;
  logic [4:0]  fill_r, fill_nxt;

  // Result pipeline.
  logic        s1_v_r, s1_v_nxt;
  res_t        s1_r;
  logic        out_v_r;
  kind_t       out_kind_r;
  logic [7:0]  out_data_r;
  logic [15:0] out_faddr_r;
  logic        out_busy_r;

  logic        accept;
  logic        s1_adv;
  op_t         op;
  logic        in_vram;
  logic        bank_sel;
  logic [OFS_W-1:0] bus_off, dma_off, mem_off;
  logic [IDX_W-1:0] mem_idx;
  logic        mem_rd, mem_wr;
  logic [7:0]  mem_wdata, mem_q;
  logic        res_v;
  res_t        res;
  logic [5:0]  cnt_dec;
  logic [11:0] rem_dec;
  logic [3:0]  fill_idx;

  assign cfg_ready = 1'b1;
  assign s1_adv    = !out_v_r || out_ready;
  assign in_ready  = !s1_v_r || s1_adv;
  assign accept    = in_valid && in_ready;
  assign op        = op_t'(in_operation);

  assign in_vram  = (in_address >= VRAM_BASE) &&
                    ({1'b0, in_address} < (17'(VRAM_BASE) + 17'(BANK_BYTES)));
  assign bank_sel = color_mode_r & bank_r[0];
  assign bus_off  = in_address[OFS_W-1:0];
  assign fill_idx = 4'(fill_r - 5'd1);
  assign dma_off  = wrap_bank(dst_ptr_r + 13'(fill_idx));
  assign mem_off  = (op == OP_DMA) ? dma_off : bus_off;
  assign mem_idx  = bank_sel ? (IDX_W'(BANK_BYTES) + IDX_W'(mem_off)) : IDX_W'(mem_off);
  assign cnt_dec  = (cnt_r != 6'd0) ? cnt_r - 6'd1 : 6'd0;
  assign rem_dec  = (rem_r >= 12'(BLOCK_BYTES)) ? rem_r - 12'(BLOCK_BYTES) : 12'd0;

  always_comb begin
    bank_nxt    = bank_r;
    src_hi_nxt  = src_hi_r;
    src_lo_nxt  = src_lo_r;
    dst_hi_nxt  = dst_hi_r;
    dst_lo_nxt  = dst_lo_r;
    len_nxt     = len_r;
    active_nxt  = active_r;
    hblank_nxt  = hblank_r;
    cnt_nxt     = cnt_r;
    src_ptr_nxt = src_ptr_r;
    dst_ptr_nxt = dst_ptr_r;
    rem_nxt     = rem_r;
    fill_nxt    = fill_r;
    mem_rd      = 1'b0;
    mem_wr      = 1'b0;
    mem_wdata   = in_write_data;
    res_v       = 1'b0;
    res         = '{kind: KIND_READ, use_mem: 1'b0, reg_data: 8'd0,
                    fetch_addr: 16'd0, busy: active_r};
    if (accept) begin
      case (op)
        OP_READ: begin
          res_v       = 1'b1;
          res.use_mem = in_vram;
          mem_rd      = in_vram;
          case (in_address)
            ADDR_BANK:   res.reg_data = bank_r;
            ADDR_SRC_HI: res.reg_data = src_hi_r;
            ADDR_SRC_LO: res.reg_data = src_lo_r;
            ADDR_DST_HI: res.reg_data = dst_hi_r;
            ADDR_DST_LO: res.reg_data = dst_lo_r;
            ADDR_CTRL:   res.reg_data = len_r;
            default:     res.reg_data = UNMAPPED;
          endcase
        end
        OP_WRITE: begin
          if (in_vram) begin
            mem_wr = 1'b1;
          end else begin
            case (in_address)
              ADDR_BANK:   bank_nxt   = in_write_data;
              ADDR_SRC_HI: src_hi_nxt = in_write_data;
              ADDR_SRC_LO: src_lo_nxt = in_write_data & LO_MASK;
              ADDR_DST_HI: dst_hi_nxt = in_write_data & DST_HI_MASK;
              ADDR_DST_LO: dst_lo_nxt = in_write_data & LO_MASK;
              ADDR_CTRL: begin
                if (active_r) begin
                  // cancel only; a write with bit 7 set is dropped
                  if ((in_write_data & CTRL_HBLANK) == 8'd0) begin
                    active_nxt = 1'b0;
                    fill_nxt   = 5'd0;
                    len_nxt    = len_r | CTRL_HBLANK;
                  end
                end else begin
                  active_nxt  = 1'b1;
                  len_nxt     = in_write_data & LEN_MASK;
                  src_ptr_nxt = {src_hi_r, src_lo_r};
                  dst_ptr_nxt = {dst_hi_r[4:0], dst_lo_r};
                  rem_nxt     = (12'(in_write_data[6:0]) + 12'd1) << 4;
                  hblank_nxt  = in_write_data[7];
                  cnt_nxt     = TICKS_PER_BLOCK;
                  fill_nxt    = 5'd0;
                end
              end
              default: ;
            endcase
          end
        end
        OP_TICK: begin
          if (active_r && fill_r == 5'd0 && !(hblank_r && in_display_mode != 2'd0)) begin
            cnt_nxt = cnt_dec;
            if (cnt_dec == 6'd0) begin
              fill_nxt       = 5'd1;
              res_v          = 1'b1;
              res.kind       = KIND_FETCH;
              res.fetch_addr = src_ptr_r;
              res.busy       = 1'b1;
            end
          end
        end
        OP_DMA: begin
          if (fill_r != 5'd0 && active_r) begin
            mem_wr    = 1'b1;
            mem_wdata = in_dma_byte;
            if (fill_r < 5'(BLOCK_BYTES)) begin
              fill_nxt = fill_r + 5'd1;
            end else begin
              fill_nxt = 5'd0;
              rem_nxt  = rem_dec;
              if (rem_dec == 12'd0) begin
                active_nxt = 1'b0;
                len_nxt    = REG_RESET;
              end else begin
                len_nxt     = len_r - 8'd1;
                src_ptr_nxt = src_ptr_r + 16'(BLOCK_BYTES);
                dst_ptr_nxt = dst_ptr_r + 13'(BLOCK_BYTES);
                cnt_nxt     = TICKS_PER_BLOCK;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign s1_v_nxt = in_ready ? (accept && res_v) : s1_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
      bank_r       <= REG_RESET;
      src_hi_r     <= REG_RESET;
      src_lo_r     <= REG_RESET;
      dst_hi_r     <= REG_RESET;
      dst_lo_r     <= REG_RESET;
      len_r        <= REG_RESET;
      active_r     <= 1'b0;
      hblank_r     <= 1'b0;
      cnt_r        <= 6'd0;
      src_ptr_r    <= 16'd0;
      dst_ptr_r    <= 13'd0;
      rem_r        <= 12'd0;
      fill_r       <= 5'd0;
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (cfg_valid) color_mode_r <= cfg_color_mode;
      bank_r    <= bank_nxt;
      src_hi_r  <= src_hi_nxt;
      src_lo_r  <= src_lo_nxt;
      dst_hi_r  <= dst_hi_nxt;
      dst_lo_r  <= dst_lo_nxt;
      len_r     <= len_nxt;
      active_r  <= active_nxt;
      hblank_r  <= hblank_nxt;
      cnt_r     <= cnt_nxt;
      src_ptr_r <= src_ptr_nxt;
      dst_ptr_r <= dst_ptr_nxt;
      rem_r     <= rem_nxt;
      fill_r    <= fill_nxt;
      s1_v_r    <= s1_v_nxt;
      if (s1_adv) out_v_r <= s1_v_r;
    end
  end

  // Payload stages: load the read stage whenever it frees up, advance on space.
  always_ff @(posedge clk) begin
    if (in_ready) s1_r <= res;
    if (s1_adv) begin
      out_kind_r  <= s1_r.kind;
      out_data_r  <= s1_r.use_mem ? mem_q : s1_r.reg_data;
      out_faddr_r <= s1_r.fetch_addr;
      out_busy_r  <= s1_r.busy;
    end
  end

  bvr_vram #(
    .DEPTH(DEPTH)
  ) u_vram (
    .clk     (clk),
    .rd_en   (mem_rd),
    .wr_en   (mem_wr),
    .addr    (mem_idx),
    .wr_data (mem_wdata),
    .rd_data (mem_q)
  );

  assign out_valid         = out_v_r;
  assign out_kind          = out_kind_r;
  assign out_read_data     = out_data_r;
  assign out_fetch_address = out_faddr_r;
  assign out_copy_busy     = out_busy_r;

  `BVR_ASSERT(a_fill_range, fill_r <= 5'(BLOCK_BYTES), "block fill index out of range")
  `BVR_ASSERT(a_fill_needs_active, (fill_r != 5'd0) |-> active_r, "block pending while idle")
  `BVR_ASSERT(a_active_has_bytes, active_r |-> (rem_r != 12'd0), "copy active with nothing left")
  `BVR_ASSERT(a_s1_hold, (s1_v_r && !s1_adv) |=> (s1_v_r && $stable(s1_r)), "read stage lost")
  `BVR_ASSERT_ALWAYS(a_no_accept_on_stall, !(accept && s1_v_r && !s1_adv), "beat taken on stall")

endmodule

// ===== sv/bvr_vram.sv =====
// Single-port video RAM with registered read data.
module bvr_vram
  import bvr_pkg::*;
#(
  parameter int DEPTH = 2 * BANK_BYTES_DEF
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [7:0]               wr_data,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== tb/banked_video_ram_with_block_dma_tb.sv =====
// Self-checking bench for the banked video RAM with its block copy engine.
module banked_video_ram_with_block_dma_tb;
  import bvr_pkg::*;

  localparam int BANK          = BANK_BYTES_DEF;
  localparam int ITEMS         = 1950;
  localparam int HOLD_CYCLES   = 80;
  localparam int SETTLE_CYCLES = 6;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    op_t         op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [1:0]  mode;
    logic [7:0]  dbyte;
  } access_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  rdata;
    logic [15:0] faddr;
    logic        busy;
  } answer_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic [1:0]  mode;
    logic [7:0]  dbyte;
    logic        typed;
    logic [7:0]  rdata;
    logic        busy;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_color_mode = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_operation = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic [1:0]  in_display_mode = '0;
  logic [7:0]  in_dma_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_read_data;
  logic [15:0] out_fetch_address;
  logic        out_copy_busy;

  banked_video_ram_with_block_dma #(.BANK_BYTES(BANK)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_color_mode    (cfg_color_mode),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_address        (in_address),
    .in_write_data     (in_write_data),
    .in_display_mode   (in_display_mode),
    .in_dma_byte       (in_dma_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_read_data     (out_read_data),
    .out_fetch_address (out_fetch_address),
    .out_copy_busy     (out_copy_busy)
  );

  always #5 clk = ~clk;

  // Mirror of the block state
  logic [7:0]  mem_img [2*BANK];
  bit          mem_known [2*BANK];
  int          known_list [$];
  logic [7:0]  bank_r, src_hi_r, src_lo_r, dst_hi_r, dst_lo_r, len_r;
  logic        copying, hblank_mode, color_on;
  logic [5:0]  ticks_left;
  logic [15:0] src_ptr;
  logic [12:0] dst_ptr;
  logic [11:0] bytes_left;
  logic [4:0]  fill_pos;

  answer_t bus_answers [$];

  int fetches_issued = 0;
  int copies_started = 0;
  int accesses_sent = 0;
  int accesses_live = 0;
  int reads_checked = 0;
  int fetches_checked = 0;
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int idle_plan [4]  = '{0, 55, 0, 19};
  int stall_plan [4] = '{0, 0, 55, 19};

  row_t plan [24] = '{
    '{OP_READ,  ADDR_BANK,   8'h00, 2'd0, 8'h00, 1'b1, REG_RESET,   1'b0},
    '{OP_READ,  ADDR_SRC_HI, 8'h00, 2'd0, 8'h00, 1'b1, REG_RESET,   1'b0},
    '{OP_READ,  ADDR_CTRL,   8'h00, 2'd0, 8'h00, 1'b1, REG_RESET,   1'b0},
    '{OP_READ,  16'h0000,    8'h00, 2'd0, 8'h00, 1'b1, UNMAPPED,    1'b0},
    '{OP_READ,  16'hFFFF,    8'hFF, 2'd3, 8'hFF, 1'b1, UNMAPPED,    1'b0},
    '{OP_WRITE, VRAM_BASE,   8'h00, 2'd0, 8'h00, 1'b0, 8'h00,       1'b0},
    '{OP_WRITE, 16'h9FFF,    8'hFF, 2'd0, 8'h00, 1'b0, 8'h00,       1'b0},
    '{OP_READ,  VRAM_BASE,   8'h00, 2'd0, 8'h00, 1'b1, 8'h00,       1'b0},
    '{OP_READ,  16'h9FFF,    8'h00, 2'd0, 8'h00, 1'b1, 8'hFF,       1'b0},
    '{OP_WRITE, 16'hA000,    8'h5A, 2'd0, 8'h00, 1'b0, 8'h00,       1'b0},
    '{OP_READ,  16'hA000,    8'h00, 2'd0, 8'h00, 1'b1, UNMAPPED,    1'b0},
    '{OP_WRITE, ADDR_SRC_LO, 8'hFF, 2'd0, 8'h00, 1'b0, 8'h00,       1'b0},
    '{OP_WRITE, ADDR_DST_HI, 8'hFF, 2'd0, 8'h00, 1'b0, 8'h00,       1'b0},
    '{OP_WRITE, ADDR_DST_LO, 8'h0F, 2'd0, 8'h00, 1'b0, 8'h00,       1'b0},
    '{OP_READ,  ADDR_SRC_LO, 8'h00, 2'd0, 8'h00, 1'b1, 8'hF0,       1'b0},
    '{OP_READ,  ADDR_DST_HI, 8'h00, 2'd0, 8'h00, 1'b1, 8'h1F,       1'b0},
    '{OP_READ,  ADDR_DST_LO, 8'h00, 2'd0, 8'h00, 1'b1, 8'h00,       1'b0},
    '{OP_TICK,  16'h0000,    8'h00, 2'd3, 8'h00, 1'b0, 8'h00,       1'b0},
    '{OP_DMA,   16'h0000,    8'h00, 2'd0, 8'hFF, 1'b0, 8'h00,       1'b0},
    '{OP_WRITE, ADDR_CTRL,   8'h00, 2'd0, 8'h00, 1'b0, 8'h00,       1'b0},
    '{OP_WRITE, ADDR_CTRL,   CTRL_HBLANK, 2'd0, 8'h00, 1'b0, 8'h00, 1'b0},
    '{OP_READ,  ADDR_CTRL,   8'h00, 2'd0, 8'h00, 1'b1, 8'h00,       1'b1},
    '{OP_WRITE, ADDR_CTRL,   8'h00, 2'd0, 8'h00, 1'b0, 8'h00,       1'b0},
    '{OP_READ,  ADDR_CTRL,   8'h00, 2'd0, 8'h00, 1'b1, CTRL_HBLANK, 1'b0}
  };

  function automatic int bank_base();
    return (color_on && bank_r[0]) ? BANK : 0;
  endfunction

  function automatic bit in_vram(logic [15:0] addr);
    return addr >= VRAM_BASE && int'(addr) < int'(VRAM_BASE) + BANK;
  endfunction

  function automatic void store_byte(int idx, logic [7:0] v);
    mem_img[idx] = v;
    if (!mem_known[idx]) begin
      mem_known[idx] = 1'b1;
      known_list.push_back(idx);
    end
  endfunction

  // Apply one access to the mirror; returns 1 when the block answers it.
  function automatic bit apply_access(input access_t a, output answer_t ans,
                                      output bit counted);
    int base;
    logic [12:0] off;
    bit has;
    base = bank_base();
    ans = '0;
    counted = 1'b1;
    has = 1'b0;
    case (a.op)
      OP_READ: begin
        has = 1'b1;
        ans.kind = KIND_READ;
        ans.busy = copying;
        if (in_vram(a.addr)) ans.rdata = mem_img[base + int'(a.addr - VRAM_BASE)];
        else begin
          case (a.addr)
            ADDR_BANK:   ans.rdata = bank_r;
            ADDR_SRC_HI: ans.rdata = src_hi_r;
            ADDR_SRC_LO: ans.rdata = src_lo_r;
            ADDR_DST_HI: ans.rdata = dst_hi_r;
            ADDR_DST_LO: ans.rdata = dst_lo_r;
            ADDR_CTRL:   ans.rdata = len_r;
            default:     ans.rdata = UNMAPPED;
          endcase
        end
      end
      OP_WRITE: begin
        if (in_vram(a.addr)) store_byte(base + int'(a.addr - VRAM_BASE), a.wdata);
        else begin
          case (a.addr)
            ADDR_BANK:   bank_r = a.wdata;
            ADDR_SRC_HI: src_hi_r = a.wdata;
            ADDR_SRC_LO: src_lo_r = a.wdata & LO_MASK;
            ADDR_DST_HI: dst_hi_r = a.wdata & DST_HI_MASK;
            ADDR_DST_LO: dst_lo_r = a.wdata & LO_MASK;
            ADDR_CTRL: begin
              if (copying) begin
                // cancel drops the pending block and never restarts
                if ((a.wdata & CTRL_HBLANK) == 8'h00) begin
                  copying = 1'b0;
                  fill_pos = '0;
                  len_r = len_r | CTRL_HBLANK;
                end else counted = 1'b0;
              end else begin
                copying = 1'b1;
                len_r = a.wdata & LEN_MASK;
                src_ptr = {src_hi_r, src_lo_r};
                dst_ptr = 13'({dst_hi_r, dst_lo_r});
                bytes_left = ({4'd0, len_r} + 12'd1) << 4;
                hblank_mode = (a.wdata & CTRL_HBLANK) != 8'h00;
                ticks_left = TICKS_PER_BLOCK;
                fill_pos = '0;
              end
            end
            default: counted = 1'b0;
          endcase
        end
      end
      OP_DMA: begin
        if (fill_pos == 5'd0 || !copying) counted = 1'b0;
        else begin
          off = dst_ptr + 13'(fill_pos - 5'd1);
          store_byte(base + int'(off) % BANK, a.dbyte);
          if (fill_pos < 5'(BLOCK_BYTES)) fill_pos = fill_pos + 5'd1;
          else begin
            fill_pos = '0;
            bytes_left = (bytes_left >= 12'(BLOCK_BYTES)) ?
                         bytes_left - 12'(BLOCK_BYTES) : '0;
            if (bytes_left == 12'd0) begin
              copying = 1'b0;
              len_r = REG_RESET;
            end else begin
              len_r = len_r - 8'd1;
              src_ptr = src_ptr + 16'(BLOCK_BYTES);
              dst_ptr = dst_ptr + 13'(BLOCK_BYTES);
              ticks_left = TICKS_PER_BLOCK;
            end
          end
        end
      end
      default: begin
        if (!copying || fill_pos != 5'd0 || (hblank_mode && a.mode != 2'd0)) counted = 1'b0;
        else begin
          if (ticks_left > 6'd0) ticks_left = ticks_left - 6'd1;
          if (ticks_left == 6'd0) begin
            fill_pos = 5'd1;
            fetches_issued++;
            has = 1'b1;
            ans.kind = KIND_FETCH;
            ans.faddr = src_ptr;
            ans.busy = 1'b1;
          end
        end
      end
    endcase
    return has;
  endfunction

  function automatic access_t rand_access(op_t op);
    access_t a;
    a.op = op;
    a.addr = 16'($urandom);
    a.wdata = 8'($urandom);
    a.mode = 2'($urandom);
    a.dbyte = 8'($urandom);
    return a;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch, %s: expected 0x%0h got 0x%0h at cycle %0d", what, want, got, cycles);
    mismatches++;
  endtask

  // Offer one beat, hold it until taken, then update the mirror.
  task automatic send_access(input access_t a);
    answer_t ans;
    bit counted;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_operation    <= a.op;
    in_address      <= a.addr;
    in_write_data   <= a.wdata;
    in_display_mode <= a.mode;
    in_dma_byte     <= a.dbyte;
    do @(posedge clk); while (!in_ready);
    if (apply_access(a, ans, counted)) bus_answers.push_back(ans);
    accesses_sent++;
    if (counted) accesses_live++;
  endtask

  task automatic send_write(input logic [15:0] addr, input logic [7:0] data);
    access_t a;
    a = rand_access(OP_WRITE);
    a.addr = addr;
    a.wdata = data;
    send_access(a);
  endtask

  // Never read a VRAM byte that has not been written in the current bank.
  task automatic send_read();
    access_t a;
    int r, idx, base;
    bit found;
    a = rand_access(OP_READ);
    r = $urandom_range(99);
    base = bank_base();
    found = 1'b0;
    if (r < 30) begin
      case ($urandom_range(5))
        0: a.addr = ADDR_BANK;
        1: a.addr = ADDR_SRC_HI;
        2: a.addr = ADDR_SRC_LO;
        3: a.addr = ADDR_DST_HI;
        4: a.addr = ADDR_DST_LO;
        default: a.addr = ADDR_CTRL;
      endcase
    end else if (r < 60) begin
      a.addr = ADDR_CTRL;
      for (int i = 0; i < 8 && !found && known_list.size() != 0; i++) begin
        idx = known_list[$urandom_range(known_list.size() - 1)];
        if (idx >= base && idx < base + BANK) begin
          a.addr = VRAM_BASE + 16'(idx - base);
          found = 1'b1;
        end
      end
    end else if (in_vram(a.addr) && !mem_known[base + int'(a.addr - VRAM_BASE)]) begin
      a.addr[13] = 1'b1;
    end
    send_access(a);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (bus_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_color(input logic v);
    cfg_valid      <= 1'b1;
    cfg_color_mode <= v;
    do @(posedge clk); while (!cfg_ready);
    color_on = v;
    cfg_valid <= 1'b0;
  endtask

  // Program a copy, then feed ticks and source bytes until it ends.
  task automatic run_copy();
    access_t a;
    int r, cancel_after, first_fetch;
    logic [7:0] len;
    send_write(ADDR_SRC_HI, 8'($urandom));
    send_write(ADDR_SRC_LO, 8'($urandom));
    if ($urandom_range(9) == 0) begin
      // top of VRAM: a following block wraps back to offset zero
      send_write(ADDR_DST_HI, 8'hFF);
      send_write(ADDR_DST_LO, 8'hF0 | 8'($urandom_range(15)));
    end else begin
      send_write(ADDR_DST_HI, 8'($urandom));
      send_write(ADDR_DST_LO, 8'($urandom));
    end
    if ($urandom_range(2) == 0) send_write(ADDR_BANK, 8'($urandom));
    len = ($urandom_range(11) == 0) ? LEN_MASK : 8'($urandom_range(2));
    if (len == LEN_MASK) cancel_after = $urandom_range(1, 2);
    else cancel_after = ($urandom_range(6) == 0) ? $urandom_range(0, int'(len)) : -1;
    first_fetch = fetches_issued;
    send_write(ADDR_CTRL, ($urandom_range(1) ? CTRL_HBLANK : 8'h00) | len);
    copies_started++;
    while (copying) begin
      r = $urandom_range(99);
      if (cancel_after >= 0 && fetches_issued - first_fetch >= cancel_after && r < 5) begin
        send_write(ADDR_CTRL, 8'($urandom) & LEN_MASK);
      end else if (fill_pos != 5'd0) begin
        if (r < 82) send_access(rand_access(OP_DMA));
        else if (r < 90) send_access(rand_access(OP_TICK));
        else if (r < 96) send_read();
        else send_write(ADDR_CTRL, 8'($urandom) | CTRL_HBLANK);
      end else begin
        if (r < 78) begin
          a = rand_access(OP_TICK);
          if ($urandom_range(99) < 60) a.mode = 2'd0;
          send_access(a);
        end else if (r < 88) send_read();
        else if (r < 92) send_write(VRAM_BASE | 16'($urandom_range(BANK - 1)), 8'($urandom));
        else if (r < 96) send_access(rand_access(OP_DMA));
        else send_write(ADDR_CTRL, 8'($urandom) | CTRL_HBLANK);
      end
    end
    // late source bytes after a cancel land nowhere
    if (cancel_after >= 0) repeat ($urandom_range(2)) send_access(rand_access(OP_DMA));
  endtask

  task automatic bus_burst();
    access_t a;
    repeat ($urandom_range(8, 24)) begin
      case ($urandom_range(9))
        0, 1, 2, 3: send_read();
        4, 5: send_write(VRAM_BASE | 16'($urandom_range(BANK - 1)), 8'($urandom));
        6: send_write(ADDR_BANK, 8'($urandom));
        7: send_write(ADDR_SRC_HI + 16'($urandom_range(3)), 8'($urandom));
        8: begin
          a = rand_access(OP_WRITE);
          if (a.addr == ADDR_CTRL) a.addr = 16'h0000;
          send_access(a);
        end
        default: send_access(rand_access($urandom_range(1) ? OP_DMA : OP_TICK));
      endcase
    end
  endtask

  // Receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_beats
    answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (bus_answers.size() == 0) report_mismatch("beat with nothing expected", 0, out_kind);
      else begin
        want = bus_answers.pop_front();
        if (out_kind !== want.kind) report_mismatch("kind", want.kind, out_kind);
        if (out_read_data !== want.rdata) report_mismatch("read_data", want.rdata, out_read_data);
        if (out_fetch_address !== want.faddr)
          report_mismatch("fetch_address", want.faddr, out_fetch_address);
        if (out_copy_busy !== want.busy) report_mismatch("copy_busy", want.busy, out_copy_busy);
        if (want.kind == KIND_FETCH) fetches_checked++;
        else reads_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("banked_video_ram_with_block_dma_tb: FAIL");
      $finish;
    end
  end

  initial begin
    bank_r = REG_RESET;
    src_hi_r = REG_RESET;
    src_lo_r = REG_RESET;
    dst_hi_r = REG_RESET;
    dst_lo_r = REG_RESET;
    len_r = REG_RESET;
    copying = 1'b0;
    hblank_mode = 1'b0;
    color_on = 1'b0;
    ticks_left = '0;
    src_ptr = '0;
    dst_ptr = '0;
    bytes_left = '0;
    fill_pos = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_color(1'b0);

    foreach (plan[i]) begin
      send_access('{plan[i].op, plan[i].addr, plan[i].wdata, plan[i].mode, plan[i].dbyte});
      if (plan[i].typed) bus_answers[$] = '{KIND_READ, plan[i].rdata, 16'h0000, plan[i].busy};
    end

    for (int p = 0; p < 4; p++) begin
      settle();
      send_idle_pct = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      set_color(p % 2 == 0);
      if (p == 0) begin
        // stall the output long enough to back up the input, then drain
        hold_token <= hold_token + 1;
        repeat (30) send_read();
        settle();
      end
      while (accesses_sent < ITEMS * (p + 1) / 4) begin
        if ($urandom_range(99) < 60) run_copy();
        else bus_burst();
      end
    end
    settle();

    $display("Ran %0d accesses (%0d effective) in both color modes under four idle patterns,",
             accesses_sent, accesses_live);
    $display("checking %0d read beats and %0d block fetch beats over %0d copies.",
             reads_checked, fetches_checked, copies_started);
    if (mismatches == 0) $display("banked_video_ram_with_block_dma_tb: PASS");
    else $display("banked_video_ram_with_block_dma_tb: FAIL");
    $finish;
  end

endmodule
